// ===== rtl/core/ihex_pkg.sv =====
package ihex_pkg;

   // Parameter range and defaults
   localparam int MAX_DATA_BYTES_DEFAULT = 16;
   localparam int MAX_DATA_BYTES_LIMIT   = 32;

   // Command field widths cover the whole parameter range
   localparam int LEN_W  = $clog2(MAX_DATA_BYTES_LIMIT + 1);
   localparam int NRES_W = $clog2(MAX_DATA_BYTES_LIMIT / 4 + 1);

   localparam int QUEUE_DEPTH = 2;

   // Configuration port
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 32;
   localparam logic [CSR_INDEX_W-1:0] CSR_APP_BASE      = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INITIAL_UPPER = 1'd1;

   localparam logic [31:0] APP_BASE_RESET      = 32'h0800_0000;
   localparam logic [15:0] INITIAL_UPPER_RESET = 16'h0800;

   typedef enum logic [2:0] {
      KIND_WRITE      = 3'd0,
      KIND_EOF        = 3'd1,
      KIND_START      = 3'd2,
      KIND_CHECKSUM   = 3'd3,
      KIND_BELOW_BASE = 3'd4,
      KIND_FORMAT     = 3'd5
   } kind_type;

   // One finished record (or error) handed from the parser to the emitter
   typedef struct packed {
      logic              is_words;  // data record: emit nres words
      kind_type          kind;      // result kind when not a data record
      logic              fail;      // final word result is an address-below-base error
      logic [31:0]       addr;      // first word address, or result address
      logic [LEN_W-1:0]  len;       // data byte count, for zero padding
      logic [NRES_W-1:0] nres;      // number of results to emit
   } cmd_type;

endpackage

// ===== rtl/core/intel_hex_record_decoder.sv =====
// Intel HEX record decoder: takes HEX text one character per transfer on the req_ channel and
// returns results on the rsp_ channel. The parser accepts one character every cycle; it stalls
// only when its two-entry command queue is full, which happens when the rsp_ side holds off.
// A character causes at most one queued command, and the emitter turns a command into results
// at one per cycle unless rsp_stall holds it: a data record of n bytes gives ceil(n/4) word
// results (fewer if an address falls below app_base, the last result then being the address
// error), every other command gives one. Results of one character are contiguous and the final
// one carries rsp_last. Configuration writes through csr_ take effect on the next cycle; write
// them only while the block is idle. There is no clearing pass after reset.
module intel_hex_record_decoder import ihex_pkg::*; #(
   parameter int MAX_DATA_BYTES = MAX_DATA_BYTES_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_char_in,
   input  logic                   req_buffer_start,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [2:0]             rsp_kind,
   output logic [31:0]            rsp_address,
   output logic [31:0]            rsp_data,
   output logic                   rsp_last,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic [31:0]                 app_base_ff;
   logic [15:0]                 initial_upper_ff;

   logic                        push_valid;
   cmd_type                     push_cmd;
   logic [MAX_DATA_BYTES*8-1:0] push_bytes;
   logic                        queue_full;
   logic                        queue_empty;
   logic                        pop;
   cmd_type                     head_cmd;
   logic [MAX_DATA_BYTES*8-1:0] head_bytes;

   // Configuration registers; hold until written again
   always_ff @(posedge clock) begin
      if (reset) begin
         app_base_ff      <= APP_BASE_RESET;
         initial_upper_ff <= INITIAL_UPPER_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_APP_BASE:      app_base_ff      <= csr_wdata[31:0];
            CSR_INITIAL_UPPER: initial_upper_ff <= csr_wdata[15:0];
            default: begin
            end
         endcase
      end
   end

   // Front: parse characters, check addresses, queue at most one command per record or error
   ihex_front #(
      .MAX_DATA_BYTES (MAX_DATA_BYTES)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_char_in      (req_char_in),
      .req_buffer_start (req_buffer_start),
      .app_base         (app_base_ff),
      .initial_upper    (initial_upper_ff),
      .queue_full       (queue_full),
      .push_valid       (push_valid),
      .push_cmd         (push_cmd),
      .push_bytes       (push_bytes)
   );

   // Decouple parsing from result delivery
   ihex_queue #(
      .MAX_DATA_BYTES (MAX_DATA_BYTES)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .push_bytes (push_bytes),
      .pop        (pop),
      .full       (queue_full),
      .empty      (queue_empty),
      .head_cmd   (head_cmd),
      .head_bytes (head_bytes)
   );

   // Back: advance through each command, one registered result per transfer
   ihex_back #(
      .MAX_DATA_BYTES (MAX_DATA_BYTES)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .head_cmd    (head_cmd),
      .head_bytes  (head_bytes),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_kind    (rsp_kind),
      .rsp_address (rsp_address),
      .rsp_data    (rsp_data),
      .rsp_last    (rsp_last)
   );

endmodule

// ===== rtl/core/ihex_front.sv =====
module ihex_front import ihex_pkg::*; #(
   parameter int MAX_DATA_BYTES = MAX_DATA_BYTES_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [7:0]                  req_char_in,
   input  logic                        req_buffer_start,
   input  logic [31:0]                 app_base,
   input  logic [15:0]                 initial_upper,
   input  logic                        queue_full,
   output logic                        push_valid,
   output cmd_type                     push_cmd,
   output logic [MAX_DATA_BYTES*8-1:0] push_bytes
);

   localparam int WORDS  = (MAX_DATA_BYTES + 3) / 4;
   localparam int POS_W  = $clog2(2 * MAX_DATA_BYTES + 11);
   localparam int LW     = $clog2(MAX_DATA_BYTES + 1);
   localparam int IDX_W  = $clog2(MAX_DATA_BYTES);
   localparam int WIDX   = $clog2(WORDS + 1);

   localparam logic [7:0] CHAR_COLON  = 8'h3A;
   localparam logic [7:0] BIAS_UPPER  = 8'h37;
   localparam logic [7:0] BIAS_LOWER  = 8'h57;
   localparam logic [7:0] BIAS_DIGIT  = 8'h30;
   localparam logic [7:0] REC_DATA    = 8'h00;
   localparam logic [7:0] REC_EOF     = 8'h01;
   localparam logic [7:0] REC_UPPER   = 8'h04;
   localparam logic [7:0] REC_START   = 8'h05;

   // bit 4 flags a valid hex digit
   function automatic logic [4:0] hex_decode(input logic [7:0] c);
      logic [4:0] r;
      r = '0;
      if (c inside {[8'h41:8'h46]}) begin
         r = {1'b1, 4'(c - BIAS_UPPER)};
      end else if (c inside {[8'h61:8'h66]}) begin
         r = {1'b1, 4'(c - BIAS_LOWER)};
      end else if (c inside {[8'h30:8'h39]}) begin
         r = {1'b1, 4'(c - BIAS_DIGIT)};
      end
      return r;
   endfunction

   logic [POS_W-1:0]  pos_ff, pos_in;
   logic              in_record_ff, in_record_in;
   logic [3:0]        high_nib_ff, high_nib_in;
   logic [LW-1:0]     len_ff, len_in;
   logic [15:0]       offset_ff, offset_in;
   logic [7:0]        type_ff, type_in;
   logic [7:0]        sum_ff, sum_in;
   logic [15:0]       upper_ff, upper_in;
   logic              err_ff, err_in;
   logic [31:0]       chk_addr_ff, chk_addr_in;
   logic [WIDX-1:0]   chk_idx_ff, chk_idx_in;
   logic              fail_found_ff, fail_found_in;
   logic [WIDX-1:0]   fail_idx_ff, fail_idx_in;
   logic [7:0]        data_bytes_ff [MAX_DATA_BYTES];

   logic              accept;
   logic [4:0]        nib;
   logic [7:0]        byte_val;
   logic [POS_W-2:0]  byte_num;
   logic [7:0]        sum_new;
   logic              data_we;
   logic [IDX_W-1:0]  data_waddr;
   logic [WIDX-1:0]   word_count;
   logic              fail_now;
   logic              step;
   logic [7:0]        byte0;
   logic [7:0]        byte1;

   assign req_stall  = queue_full;
   assign accept     = req_valid && !queue_full;
   assign nib        = hex_decode(req_char_in);
   assign byte_val   = {high_nib_ff, nib[3:0]};
   assign byte_num   = pos_ff[POS_W-1:1];
   assign sum_new    = sum_ff + byte_val;
   assign word_count = WIDX'((LW + 2)'(len_ff) + (LW + 2)'(3) >> 2);
   assign fail_now   = fail_found_ff && (fail_idx_ff < word_count);
   assign byte0      = (len_ff > LW'(0)) ? data_bytes_ff[0] : 8'h00;
   assign byte1      = (len_ff > LW'(1)) ? data_bytes_ff[1] : 8'h00;
   assign data_waddr = IDX_W'(byte_num - (POS_W - 1)'(4));

   // address check walks one word per character once the offset is known
   assign step = accept && !req_buffer_start && !err_ff && in_record_ff && nib[4] &&
                 (pos_ff >= POS_W'(6)) && (chk_idx_ff < WIDX'(WORDS));

   always_comb begin
      pos_in        = pos_ff;
      in_record_in  = in_record_ff;
      high_nib_in   = high_nib_ff;
      len_in        = len_ff;
      offset_in     = offset_ff;
      type_in       = type_ff;
      sum_in        = sum_ff;
      upper_in      = upper_ff;
      err_in        = err_ff;
      chk_addr_in   = chk_addr_ff;
      chk_idx_in    = chk_idx_ff;
      fail_found_in = fail_found_ff;
      fail_idx_in   = fail_idx_ff;
      data_we       = 1'b0;
      push_valid    = 1'b0;
      push_cmd      = '0;
      push_cmd.nres = NRES_W'(1);
      if (accept) begin
         if (req_buffer_start) begin
            err_in       = 1'b0;
            upper_in     = initial_upper;
            in_record_in = 1'b0;
            pos_in       = '0;
            high_nib_in  = '0;
         end
         if (!err_in) begin
            if (!in_record_in) begin
               if (req_char_in == CHAR_COLON) begin
                  in_record_in = 1'b1;
                  pos_in       = '0;
                  sum_in       = '0;
                  len_in       = '0;
               end
            end else if (!nib[4]) begin
               push_valid    = 1'b1;
               push_cmd.kind = KIND_FORMAT;
               err_in        = 1'b1;
               in_record_in  = 1'b0;
            end else if (!pos_ff[0]) begin
               high_nib_in = nib[3:0];
               pos_in      = pos_ff + POS_W'(1);
            end else begin
               pos_in = pos_ff + POS_W'(1);
               sum_in = sum_new;
               if (byte_num == (POS_W - 1)'(0)) begin
                  if (byte_val > 8'(MAX_DATA_BYTES)) begin
                     push_valid    = 1'b1;
                     push_cmd.kind = KIND_FORMAT;
                     err_in        = 1'b1;
                     in_record_in  = 1'b0;
                  end else begin
                     len_in = LW'(byte_val);
                  end
               end else if (byte_num == (POS_W - 1)'(1)) begin
                  offset_in = {byte_val, 8'h00};
               end else if (byte_num == (POS_W - 1)'(2)) begin
                  offset_in     = {offset_ff[15:8], byte_val};
                  chk_addr_in   = {upper_ff, offset_ff[15:8], byte_val};
                  chk_idx_in    = '0;
                  fail_found_in = 1'b0;
               end else if (byte_num == (POS_W - 1)'(3)) begin
                  type_in = byte_val;
               end else if (POS_W'(byte_num) < POS_W'(4) + POS_W'(len_ff)) begin
                  data_we = 1'b1;
               end else begin
                  in_record_in = 1'b0;
                  if (sum_new != 8'h00) begin
                     push_valid    = 1'b1;
                     push_cmd.kind = KIND_CHECKSUM;
                     err_in        = 1'b1;
                  end else begin
                     case (type_ff)
                        REC_DATA: begin
                           if (len_ff != LW'(0)) begin
                              push_valid        = 1'b1;
                              push_cmd.is_words = 1'b1;
                              push_cmd.kind     = KIND_WRITE;
                              push_cmd.fail     = fail_now;
                              push_cmd.addr     = {upper_ff, offset_ff};
                              push_cmd.len      = LEN_W'(len_ff);
                              push_cmd.nres     = fail_now ?
                                                  NRES_W'(fail_idx_ff) + NRES_W'(1) :
                                                  NRES_W'(word_count);
                              if (fail_now) begin
                                 err_in = 1'b1;
                              end
                           end
                        end
                        REC_EOF: begin
                           push_valid    = 1'b1;
                           push_cmd.kind = KIND_EOF;
                        end
                        REC_UPPER: begin
                           upper_in = {byte0, byte1};
                        end
                        REC_START: begin
                           push_valid    = 1'b1;
                           push_cmd.kind = KIND_START;
                           push_cmd.addr = app_base;
                        end
                        default: begin
                        end
                     endcase
                  end
               end
            end
         end
      end
      if (step) begin
         if (!fail_found_ff && (chk_addr_ff < app_base)) begin
            fail_found_in = 1'b1;
            fail_idx_in   = chk_idx_ff;
         end
         chk_addr_in = chk_addr_ff + 32'd4;
         chk_idx_in  = chk_idx_ff + WIDX'(1);
      end
   end

   always_comb begin
      for (int i = 0; i < MAX_DATA_BYTES; i++) begin
         push_bytes[i*8 +: 8] = data_bytes_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         in_record_ff  <= 1'b0;
         upper_ff      <= INITIAL_UPPER_RESET;
         err_ff        <= 1'b0;
         chk_idx_ff    <= '0;
         fail_found_ff <= 1'b0;
      end else begin
         pos_ff        <= pos_in;
         in_record_ff  <= in_record_in;
         upper_ff      <= upper_in;
         err_ff        <= err_in;
         chk_idx_ff    <= chk_idx_in;
         fail_found_ff <= fail_found_in;
      end
      high_nib_ff <= high_nib_in;
      len_ff      <= len_in;
      offset_ff   <= offset_in;
      type_ff     <= type_in;
      sum_ff      <= sum_in;
      chk_addr_ff <= chk_addr_in;
      fail_idx_ff <= fail_idx_in;
      if (data_we) begin
         data_bytes_ff[data_waddr] <= byte_val;
      end
   end

   a_err_sticky: assert property (@(posedge clock) disable iff (reset)
      err_ff && accept && !req_buffer_start |-> !push_valid)
      else $error("command issued while the error is sticky");

   a_chk_bound: assert property (@(posedge clock) disable iff (reset)
      chk_idx_ff <= WIDX'(WORDS))
      else $error("address check ran past the last word");

endmodule

// ===== rtl/core/ihex_queue.sv =====
module ihex_queue import ihex_pkg::*; #(
   parameter int MAX_DATA_BYTES = MAX_DATA_BYTES_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push_valid,
   input  cmd_type                     push_cmd,
   input  logic [MAX_DATA_BYTES*8-1:0] push_bytes,
   input  logic                        pop,
   output logic                        full,
   output logic                        empty,
   output cmd_type                     head_cmd,
   output logic [MAX_DATA_BYTES*8-1:0] head_bytes
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type                     cmd_mem_ff   [QUEUE_DEPTH];
   logic [MAX_DATA_BYTES*8-1:0] bytes_mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]            wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]            rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic                        do_push;
   logic                        do_pop;

   assign full       = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty      = (count_ff == CNT_W'(0));
   assign do_push    = push_valid && !full;
   assign do_pop     = pop && !empty;
   assign head_cmd   = cmd_mem_ff[rd_ptr_ff];
   assign head_bytes = bytes_mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         cmd_mem_ff[wr_ptr_ff]   <= push_cmd;
         bytes_mem_ff[wr_ptr_ff] <= push_bytes;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> !full)
      else $error("push into a full command queue");

endmodule

// ===== rtl/core/ihex_back.sv =====
module ihex_back import ihex_pkg::*; #(
   parameter int MAX_DATA_BYTES = MAX_DATA_BYTES_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        queue_empty,
   input  cmd_type                     head_cmd,
   input  logic [MAX_DATA_BYTES*8-1:0] head_bytes,
   output logic                        pop,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [2:0]                  rsp_kind,
   output logic [31:0]                 rsp_address,
   output logic [31:0]                 rsp_data,
   output logic                        rsp_last
);

   localparam int WORDS = (MAX_DATA_BYTES + 3) / 4;
   localparam int KW    = (WORDS > 1) ? $clog2(WORDS) : 1;

   logic [KW-1:0]        k_ff, k_in;
   logic                 rsp_valid_ff;
   logic [2:0]           rsp_kind_ff;
   logic [31:0]          rsp_address_ff;
   logic [31:0]          rsp_data_ff;
   logic                 rsp_last_ff;

   logic [WORDS*32-1:0]  padded;
   logic [7:0]           byte_arr [WORDS*4];
   logic [31:0]          word_arr [WORDS];
   logic                 load;
   logic                 is_last;
   kind_type             res_kind;
   logic [31:0]          res_addr;
   logic [31:0]          res_data;

   assign padded = (WORDS * 32)'(head_bytes);

   // zero every byte past the record length
   always_comb begin
      for (int i = 0; i < WORDS * 4; i++) begin
         byte_arr[i] = (i < int'(head_cmd.len)) ? padded[i*8 +: 8] : 8'h00;
      end
      for (int w = 0; w < WORDS; w++) begin
         word_arr[w] = {byte_arr[4*w+3], byte_arr[4*w+2], byte_arr[4*w+1], byte_arr[4*w]};
      end
   end

   assign load = !queue_empty && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      if (head_cmd.is_words) begin
         is_last  = (NRES_W'(k_ff) + NRES_W'(1) == head_cmd.nres);
         res_addr = head_cmd.addr + (32'(k_ff) << 2);
         if (head_cmd.fail && is_last) begin
            res_kind = KIND_BELOW_BASE;
            res_data = '0;
         end else begin
            res_kind = KIND_WRITE;
            res_data = word_arr[k_ff];
         end
      end else begin
         is_last  = 1'b1;
         res_kind = head_cmd.kind;
         res_addr = head_cmd.addr;
         res_data = '0;
      end
      pop  = load && is_last;
      k_in = k_ff;
      if (load) begin
         k_in = is_last ? '0 : k_ff + KW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         k_ff <= k_in;
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (load) begin
         rsp_kind_ff    <= res_kind;
         rsp_address_ff <= res_addr;
         rsp_data_ff    <= res_data;
         rsp_last_ff    <= is_last;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_kind    = rsp_kind_ff;
   assign rsp_address = rsp_address_ff;
   assign rsp_data    = rsp_data_ff;
   assign rsp_last    = rsp_last_ff;

   a_below_base_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_kind_ff == KIND_BELOW_BASE) |-> rsp_last_ff)
      else $error("address error result is not the last of its character");

   a_word_index: assert property (@(posedge clock) disable iff (reset)
      !queue_empty |-> (NRES_W'(k_ff) < head_cmd.nres))
      else $error("word index ran past the result count");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;
   import ihex_pkg::*;

   localparam int MAX_BYTES    = 16;
   localparam int STALL_LIMIT  = 2000;  // cycles without any transfer
   localparam int DRAIN_CYCLES = 8;
   localparam int HOLD_CYCLES  = 400;   // long receiver hold-off

   // Record types and framing characters
   localparam logic [7:0] REC_DATA         = 8'h00;
   localparam logic [7:0] REC_EOF          = 8'h01;
   localparam logic [7:0] REC_EXT_LINEAR   = 8'h04;
   localparam logic [7:0] REC_START_LINEAR = 8'h05;
   localparam logic [7:0] COLON            = 8'h3A;
   localparam logic [7:0] CR               = 8'h0D;
   localparam logic [7:0] LF               = 8'h0A;

   typedef struct packed {
      logic [7:0] ch;
      logic       start;
   } hex_char_t;

   typedef struct packed {
      kind_type    kind;
      logic [31:0] address;
      logic [31:0] data;
      logic        last;
   } decoded_result_t;

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [7:0]             req_char_in = '0;
   logic                   req_buffer_start = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [2:0]             rsp_kind;
   logic [31:0]            rsp_address;
   logic [31:0]            rsp_data;
   logic                   rsp_last;
   logic                   csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   intel_hex_record_decoder #(.MAX_DATA_BYTES(MAX_BYTES)) uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_char_in      (req_char_in),
      .req_buffer_start (req_buffer_start),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_address      (rsp_address),
      .rsp_data         (rsp_data),
      .rsp_last         (rsp_last),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Characters waiting to be sent, and decoded results still owed by the block
   hex_char_t       hex_chars[$];
   decoded_result_t due_results[$];
   logic            char_on_bus = 1'b0;

   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   int hold_request = 0;
   int hold_left = 0;
   int mismatches = 0;
   int results_predicted = 0;
   int chars_queued = 0;
   int idle_run = 0;
   logic restart_due = 1'b0;

   // Register copies as the decoder sees them
   logic [31:0] cfg_app_base = APP_BASE_RESET;
   logic [15:0] cfg_initial_upper = INITIAL_UPPER_RESET;

   // Decoder state mirror
   logic [5:0]  dec_pos;
   logic        dec_in_rec;
   logic [3:0]  dec_hi_nib;
   logic [4:0]  dec_len;
   logic [15:0] dec_off;
   logic [7:0]  dec_type;
   logic [7:0]  dec_sum;
   logic [7:0]  dec_bytes [MAX_BYTES];
   logic [15:0] dec_upper;
   logic        dec_stuck;

   // Scratch payload for record building
   logic [7:0]  rec_payload [MAX_BYTES];

   //------------------------------------------------------------------------
   // Decoder prediction
   //------------------------------------------------------------------------
   function automatic int hex_nibble(input logic [7:0] c);
      if (c >= "A" && c <= "F") return c - 8'h37;
      if (c >= "a" && c <= "f") return c - 8'h57;
      if (c >= "0" && c <= "9") return c - 8'h30;
      return -1;
   endfunction

   function automatic logic [7:0] data_at(input int idx);
      if (idx < dec_len && idx < MAX_BYTES) return dec_bytes[idx];
      return 8'h00;
   endfunction

   task automatic reset_decoder();
      dec_pos = '0;
      dec_in_rec = 1'b0;
      dec_hi_nib = '0;
      dec_len = '0;
      dec_off = '0;
      dec_type = '0;
      dec_sum = '0;
      foreach (dec_bytes[i]) dec_bytes[i] = 8'h00;
      dec_upper = cfg_initial_upper;
      dec_stuck = 1'b0;
   endtask

   task automatic owe_result(input kind_type kind, input logic [31:0] addr,
                             input logic [31:0] data);
      due_results.push_back('{kind, addr, data, 1'b0});
      results_predicted++;
   endtask

   // Report an error once; everything after it is dropped until a buffer start
   task automatic flag_error(input kind_type kind, input logic [31:0] addr);
      dec_stuck = 1'b1;
      dec_in_rec = 1'b0;
      owe_result(kind, addr, 32'h0);
   endtask

   task automatic close_record();
      logic [31:0] addr;
      logic [31:0] word;
      logic        halted;
      halted = 1'b0;
      dec_in_rec = 1'b0;
      if (dec_sum != 8'h00) begin
         flag_error(KIND_CHECKSUM, 32'h0);
      end else begin
         case (dec_type)
            REC_DATA: begin
               for (int x = 0; x < dec_len && !halted; x += 4) begin
                  addr = {dec_upper, 16'h0000} + 32'(dec_off) + 32'(x);
                  word = {data_at(x + 3), data_at(x + 2), data_at(x + 1), data_at(x)};
                  if (addr < cfg_app_base) begin
                     flag_error(KIND_BELOW_BASE, addr);
                     halted = 1'b1;
                  end else begin
                     owe_result(KIND_WRITE, addr, word);
                  end
               end
            end
            REC_EOF:          owe_result(KIND_EOF, 32'h0, 32'h0);
            REC_EXT_LINEAR:   dec_upper = {data_at(0), data_at(1)};
            REC_START_LINEAR: owe_result(KIND_START, cfg_app_base, 32'h0);
            default: ;
         endcase
      end
   endtask

   // Advance the mirror by one character and queue the results it causes
   task automatic decode_char(input logic [7:0] c, input logic buf_start);
      int              n_before;
      int              nib;
      int              idx;
      logic [7:0]      octet;
      decoded_result_t tail;
      n_before = due_results.size();
      if (buf_start) begin
         dec_stuck = 1'b0;
         dec_upper = cfg_initial_upper;
         dec_in_rec = 1'b0;
         dec_pos = '0;
         dec_hi_nib = '0;
      end
      if (!dec_stuck) begin
         if (!dec_in_rec) begin
            if (c == COLON) begin
               dec_in_rec = 1'b1;
               dec_pos = '0;
               dec_sum = '0;
               dec_len = '0;
            end
         end else begin
            nib = hex_nibble(c);
            if (nib < 0) begin
               flag_error(KIND_FORMAT, 32'h0);
            end else if (!dec_pos[0]) begin
               dec_hi_nib = nib[3:0];
               dec_pos = dec_pos + 6'd1;
            end else begin
               octet = {dec_hi_nib, nib[3:0]};
               idx = int'(dec_pos >> 1);
               dec_pos = dec_pos + 6'd1;
               dec_sum = dec_sum + octet;
               if (idx == 0) begin
                  if (octet > MAX_BYTES) flag_error(KIND_FORMAT, 32'h0);
                  else dec_len = octet[4:0];
               end else if (idx == 1) begin
                  dec_off = {octet, 8'h00};
               end else if (idx == 2) begin
                  dec_off[7:0] = octet;
               end else if (idx == 3) begin
                  dec_type = octet;
               end else if (idx < 4 + dec_len) begin
                  dec_bytes[idx - 4] = octet;
               end else begin
                  close_record();
               end
            end
         end
      end
      // Mark the final result of this character
      if (due_results.size() > n_before) begin
         tail = due_results.pop_back();
         tail.last = 1'b1;
         due_results.push_back(tail);
      end
   endtask

   //------------------------------------------------------------------------
   // Stimulus building
   //------------------------------------------------------------------------
   task automatic queue_char(input logic [7:0] c, input logic buf_start);
      hex_chars.push_back('{c, buf_start});
      chars_queued++;
   endtask

   // Random letter case, so both 'A'-'F' and 'a'-'f' get exercised
   function automatic logic [7:0] hex_digit(input logic [3:0] v);
      if (v < 10) return "0" + v;
      return ($urandom_range(1) ? "a" : "A") + v - 10;
   endfunction

   function automatic logic [7:0] non_hex();
      logic [7:0] c;
      do c = 8'($urandom_range(255)); while (hex_nibble(c) >= 0);
      return c;
   endfunction

   function automatic logic [7:0] noise_char();
      logic [7:0] c;
      do c = 8'($urandom_range(255)); while (c == COLON);
      return c;
   endfunction

   task automatic fill_payload();
      foreach (rec_payload[i]) rec_payload[i] = 8'($urandom);
   endtask

   // Build one record from rec_payload; skew spoils the checksum, and bad_at
   // replaces that hex digit by a non-hex character and cuts the record there.
   task automatic queue_record(input logic buf_start, input logic [7:0] len_field,
                               input logic [15:0] off, input logic [7:0] rtype,
                               input logic [7:0] skew = 8'h00, input int bad_at = -1);
      logic [7:0] octs[$];
      logic [7:0] total;
      int         digit;
      octs.push_back(len_field);
      octs.push_back(off[15:8]);
      octs.push_back(off[7:0]);
      octs.push_back(rtype);
      for (int i = 0; i < len_field && i < MAX_BYTES; i++) octs.push_back(rec_payload[i]);
      total = 8'h00;
      foreach (octs[i]) total = total + octs[i];
      octs.push_back(8'h00 - total + skew);
      queue_char(COLON, buf_start);
      digit = 0;
      foreach (octs[i]) begin
         for (int h = 1; h >= 0; h--) begin
            if (digit == bad_at) begin
               queue_char(non_hex(), 1'b0);
               return;
            end
            queue_char(hex_digit(h ? octs[i][7:4] : octs[i][3:0]), 1'b0);
            digit++;
         end
      end
   endtask

   // One random record, mostly well formed, some broken, some line noise
   task automatic random_record();
      int          roll;
      int          len;
      logic        buf_start;
      logic [15:0] up;
      logic [7:0]  rtype;
      buf_start = restart_due || ($urandom_range(99) < 15);
      restart_due = 1'b0;
      fill_payload();
      roll = $urandom_range(99);
      len = $urandom_range(MAX_BYTES);
      if (roll < 45) begin
         queue_record(buf_start, 8'(len), 16'($urandom), REC_DATA);
      end else if (roll < 55) begin
         up = ($urandom_range(2) == 0) ? 16'($urandom) : cfg_initial_upper;
         rec_payload[0] = up[15:8];
         rec_payload[1] = up[7:0];
         len = ($urandom_range(6) == 0) ? $urandom_range(3) : 2;
         queue_record(buf_start, 8'(len), 16'($urandom), REC_EXT_LINEAR);
      end else if (roll < 62) begin
         queue_record(buf_start, 8'($urandom_range(2)), 16'($urandom), REC_EOF);
      end else if (roll < 68) begin
         queue_record(buf_start, 8'd4, 16'h0000, REC_START_LINEAR);
      end else if (roll < 72) begin
         do rtype = 8'($urandom_range(255));
         while (rtype == REC_DATA || rtype == REC_EOF ||
                rtype == REC_EXT_LINEAR || rtype == REC_START_LINEAR);
         queue_record(buf_start, 8'(len), 16'($urandom), rtype);
      end else if (roll < 78) begin
         queue_record(buf_start, 8'(len), 16'($urandom), 8'($urandom_range(5)),
                      8'($urandom_range(1, 255)));
         restart_due = 1'b1;
      end else if (roll < 84) begin
         queue_record(buf_start, 8'(len), 16'($urandom), REC_DATA, 8'h00,
                      $urandom_range(2 * (len + 5) - 1));
         restart_due = 1'b1;
      end else if (roll < 88) begin
         queue_record(buf_start, 8'($urandom_range(MAX_BYTES + 1, 255)), 16'($urandom),
                      REC_DATA);
         restart_due = 1'b1;
      end else if (roll < 94) begin
         repeat ($urandom_range(1, 4)) queue_char(noise_char(), $urandom_range(9) == 0);
         return;
      end else begin
         // Record cut short; the next one restarts the buffer
         queue_char(COLON, buf_start);
         repeat ($urandom_range(1, 8)) queue_char(hex_digit(4'($urandom)), 1'b0);
         restart_due = 1'b1;
         return;
      end
      if (!restart_due && $urandom_range(9) < 4) begin
         queue_char(CR, 1'b0);
         queue_char(LF, 1'b0);
      end
   endtask

   //------------------------------------------------------------------------
   // Configuration and phase control
   //------------------------------------------------------------------------
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [31:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx == CSR_APP_BASE) cfg_app_base = value;
      else cfg_initial_upper = value[15:0];
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Hold until every character is sent and every result is back, then let
   // the emitter settle
   task automatic wait_idle();
      while (hex_chars.size() != 0 || char_on_bus || due_results.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic run_phase(input logic [31:0] base, input logic [15:0] upper,
                            input int tx_pct, input int rx_pct, input logic pressure);
      int r0;
      int c0;
      int tries;
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      write_reg(CSR_APP_BASE, base);
      write_reg(CSR_INITIAL_UPPER, upper);
      if (pressure) begin
         // Stall the result side for a long stretch while short records keep
         // coming, so the command queue fills and the input stalls
         hold_request = HOLD_CYCLES;
         queue_record(1'b1, 8'd0, 16'h0000, REC_EOF);
         for (int i = 0; i < 10; i++) begin
            fill_payload();
            if (i % 2) queue_record(1'b0, 8'd0, 16'h0000, REC_EOF);
            else queue_record(1'b0, 8'd16, 16'hF000, REC_DATA);
         end
      end
      r0 = results_predicted;
      c0 = chars_queued;
      tries = 0;
      do begin
         random_record();
         while (hex_chars.size() > 4) @(negedge clock);
         tries++;
      end while (((chars_queued - c0) < 34 || (results_predicted - r0) < 12) &&
                 tries < 300);
      wait_idle();
   endtask

   //------------------------------------------------------------------------
   // Driver: offer the front character, hold it until the transfer happens
   //------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         reset_decoder();
      end else if (req_valid && !req_stall) begin
         decode_char(req_char_in, req_buffer_start);
         void'(hex_chars.pop_front());
         char_on_bus = 1'b0;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!char_on_bus) begin
         if (hex_chars.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
            req_valid <= 1'b1;
            req_char_in <= hex_chars[0].ch;
            req_buffer_start <= hex_chars[0].start;
            char_on_bus = 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: random stalls, plus a counted hold-off when one is requested
   always @(negedge clock) begin
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(99) < rx_idle_pct);
      end
   end

   //------------------------------------------------------------------------
   // Monitor: compare each result transfer with the oldest owed result
   //------------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      decoded_result_t want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_results.size() == 0) begin
            $error("unexpected result: kind %0d address %h data %h last %b",
                   rsp_kind, rsp_address, rsp_data, rsp_last);
            mismatches++;
         end else begin
            want = due_results.pop_front();
            if (rsp_kind !== want.kind) begin
               $error("kind: expected %0d, got %0d", want.kind, rsp_kind);
               mismatches++;
            end
            if (rsp_address !== want.address) begin
               $error("address: expected %h, got %h", want.address, rsp_address);
               mismatches++;
            end
            if (rsp_data !== want.data) begin
               $error("data: expected %h, got %h", want.data, rsp_data);
               mismatches++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %b, got %b", want.last, rsp_last);
               mismatches++;
            end
         end
      end
   end

   // Watchdog: end the run when no transfer happens on either side for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_run = 0;
      end else begin
         idle_run++;
         if (idle_run >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   //------------------------------------------------------------------------
   // Stimulus
   //------------------------------------------------------------------------
   initial begin : stimulus
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part, at the reset settings
      tx_idle_pct = 14;
      rx_idle_pct = 81;
      write_reg(CSR_APP_BASE, APP_BASE_RESET);
      write_reg(CSR_INITIAL_UPPER, INITIAL_UPPER_RESET);
      // Skip extreme characters and line endings outside any record
      queue_char(8'h00, 1'b1);
      queue_char(8'hFF, 1'b0);
      queue_char(CR, 1'b0);
      queue_char(LF, 1'b0);
      // Full record at exactly the base, bytes from 00 up to FF
      foreach (rec_payload[i]) rec_payload[i] = 8'(i * 17);
      queue_record(1'b0, 8'd16, 16'h0000, REC_DATA);
      // Short last word, crossing a 64K boundary
      queue_record(1'b0, 8'd5, 16'hFFFC, REC_DATA);
      // Empty data record gives nothing
      queue_record(1'b0, 8'd0, 16'h1234, REC_DATA);
      // End of file, then decoding goes on with a start request
      queue_record(1'b0, 8'd0, 16'h0000, REC_EOF);
      queue_record(1'b0, 8'd0, 16'h0000, REC_START_LINEAR);
      // Types without effect
      queue_record(1'b0, 8'd2, 16'h0000, 8'h02);
      queue_record(1'b0, 8'd0, 16'hFFFF, 8'hFF);
      // Upper address from a single byte; the missing byte reads as zero
      rec_payload[0] = 8'h08;
      queue_record(1'b0, 8'd1, 16'h0000, REC_EXT_LINEAR);
      rec_payload[0] = 8'hAB;
      queue_record(1'b0, 8'd1, 16'h0010, REC_DATA);
      // Wrap past the top: two words, then an address below the base
      rec_payload[0] = 8'hFF;
      rec_payload[1] = 8'hFF;
      queue_record(1'b0, 8'd2, 16'h0000, REC_EXT_LINEAR);
      fill_payload();
      queue_record(1'b0, 8'd12, 16'hFFF8, REC_DATA);
      // Ignored while the error holds
      queue_record(1'b0, 8'd0, 16'h0000, REC_EOF);
      // Buffer start clears it; zero-length upper record gives upper zero
      queue_record(1'b1, 8'd0, 16'h0000, REC_EXT_LINEAR);
      queue_record(1'b0, 8'd4, 16'h0100, REC_DATA);
      // Bad checksum
      queue_record(1'b1, 8'd1, 16'h0000, REC_DATA, 8'h01);
      // Colon inside a record
      queue_char(COLON, 1'b1);
      queue_char("1", 1'b0);
      queue_char(COLON, 1'b0);
      // Non-hex character among the data digits
      queue_record(1'b1, 8'd4, 16'h0000, REC_DATA, 8'h00, 10);
      // Length above the maximum
      queue_record(1'b1, 8'd17, 16'h0000, REC_DATA);
      queue_record(1'b1, 8'hFF, 16'h0000, REC_DATA);
      // Buffer start in the middle of a record drops it
      queue_char(COLON, 1'b1);
      queue_char("0", 1'b0);
      queue_char("4", 1'b0);
      queue_record(1'b1, 8'd4, 16'h0040, REC_DATA);
      wait_idle();

      // Random part: sender idles little and receiver much, then the reverse,
      // then neither, with the long hold-off in the last phase
      run_phase(32'h0000_0000, 16'h0000, 14, 81, 1'b0);
      run_phase(32'h1234_2000, 16'h1234, 14, 81, 1'b0);
      run_phase(32'hFFFF_FFFF, 16'hFFFF, 81, 14, 1'b0);
      run_phase(32'h0001_0000, 16'h0000, 81, 14, 1'b0);
      run_phase({16'($urandom), 16'h0100}, 16'h0000, 0, 0, 1'b0);
      write_reg(CSR_INITIAL_UPPER, 16'($urandom));
      run_phase({cfg_initial_upper, 16'h0100}, cfg_initial_upper, 0, 0, 1'b1);

      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/ihex_pkg.sv
rtl/core/ihex_front.sv
rtl/core/ihex_queue.sv
rtl/core/ihex_back.sv
rtl/core/intel_hex_record_decoder.sv
test/tb.sv
